[rtl/lt_pkg.sv]
// package for the four sensor light tracker step core
// field widths, mapping constants, register codes and shared structs
// no dependencies
package lt_pkg;

  localparam int SampleW = 10;
  localparam int AngleW  = 9;
  localparam int TolW    = 7;
  localparam int DelayW  = 7;
  localparam int LevelW  = 10;
  localparam int CfgIdxW = 2;
  localparam int MagW    = 9;

  localparam int LevelMax   = 300;
  localparam int MapInLow   = 10;
  localparam int TolLow     = 5;
  localparam int TolHigh    = 100;
  localparam int DelayHigh  = 100;
  localparam int DelayLow   = 50;
  localparam int DefaultVal = 50;
  localparam int MapSpan    = LevelMax - MapInLow;

  // reciprocal of the map span, exact floor for products below 2^15
  localparam int RecipShift = 24;
  localparam int Recip      = ((1 << RecipShift) + MapSpan - 1) / MapSpan;
  localparam int TolMul     = (TolHigh - TolLow) * Recip;
  localparam int DlyMul     = (DelayHigh - DelayLow) * Recip;
  localparam int ProdW      = 32;

  localparam logic [AngleW-1:0] HorizReset     = AngleW'(90);
  localparam logic [AngleW-1:0] VertReset      = AngleW'(95);
  localparam logic [AngleW-1:0] LimitLowReset  = AngleW'(0);
  localparam logic [AngleW-1:0] LimitHighReset = AngleW'(270);

  typedef enum logic [CfgIdxW-1:0] {
    CfgHorizLow  = 2'd0,
    CfgHorizHigh = 2'd1,
    CfgVertLow   = 2'd2,
    CfgVertHigh  = 2'd3
  } lt_cfg_idx_e;

  typedef struct packed {
    logic [AngleW-1:0] low;
    logic [AngleW-1:0] high;
  } lt_limit_t;

  typedef struct packed {
    logic [SampleW-1:0] top;
    logic [SampleW-1:0] bottom;
    logic [SampleW-1:0] left;
    logic [SampleW-1:0] right;
  } lt_avg_t;

  typedef struct packed {
    logic [TolW-1:0]   tolerance;
    logic [DelayW-1:0] delay_ms;
  } lt_map_t;

endpackage

[rtl/lt_if.sv]
// valid/ready channel interfaces for sample beats and result beats
// depends on lt_pkg
interface lt_in_if import lt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] top_left;
  logic [SampleW-1:0] top_right;
  logic [SampleW-1:0] bottom_left;
  logic [SampleW-1:0] bottom_right;

  modport source (output valid, top_left, top_right, bottom_left, bottom_right, input ready);
  modport sink   (input valid, top_left, top_right, bottom_left, bottom_right, output ready);
endinterface

interface lt_out_if import lt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [AngleW-1:0] horiz_angle;
  logic [AngleW-1:0] vert_angle;
  logic [TolW-1:0]   tolerance;
  logic [DelayW-1:0] delay_ms;

  modport source (output valid, horiz_angle, vert_angle, tolerance, delay_ms, input ready);
  modport sink   (input valid, horiz_angle, vert_angle, tolerance, delay_ms, output ready);
endinterface

[rtl/lt_level_map.sv]
// pair averages, overall level and level to tolerance/delay mapping
// depends on lt_pkg
module lt_level_map import lt_pkg::*; (
  input  logic [SampleW-1:0] top_left_i,
  input  logic [SampleW-1:0] top_right_i,
  input  logic [SampleW-1:0] bottom_left_i,
  input  logic [SampleW-1:0] bottom_right_i,
  output lt_avg_t            avg_o,
  output lt_map_t            map_o
);

  logic [SampleW:0]   sum_t, sum_b, sum_l, sum_r;
  logic [SampleW+1:0] sum_all;
  logic [LevelW-1:0]  level;
  logic               in_band, above_low;
  logic [LevelW-1:0]  mag_full;
  logic [MagW-1:0]    mag;
  logic [ProdW-1:0]   prod_tol, prod_dly;
  logic [TolW-1:0]    q_tol;
  logic [DelayW-1:0]  q_dly;

  always_comb begin
    sum_t = {1'b0, top_left_i} + {1'b0, top_right_i};
    sum_b = {1'b0, bottom_left_i} + {1'b0, bottom_right_i};
    sum_l = {1'b0, top_left_i} + {1'b0, bottom_left_i};
    sum_r = {1'b0, top_right_i} + {1'b0, bottom_right_i};
    avg_o.top    = sum_t[SampleW:1];
    avg_o.bottom = sum_b[SampleW:1];
    avg_o.left   = sum_l[SampleW:1];
    avg_o.right  = sum_r[SampleW:1];

    sum_all = {2'b00, avg_o.top} + {2'b00, avg_o.bottom}
            + {2'b00, avg_o.left} + {2'b00, avg_o.right};
    level   = sum_all[SampleW+1:2];

    in_band   = (level != '0) && (level < LevelW'(LevelMax));
    above_low = (level >= LevelW'(MapInLow));
    mag_full  = above_low ? (level - LevelW'(MapInLow)) : (LevelW'(MapInLow) - level);
    mag       = mag_full[MagW-1:0];

    // scaled magnitude times span reciprocal, floor is exact in band
    prod_tol = ProdW'(mag) * ProdW'(TolMul);
    prod_dly = ProdW'(mag) * ProdW'(DlyMul);
    q_tol    = prod_tol[RecipShift +: TolW];
    q_dly    = prod_dly[RecipShift +: DelayW];

    if (!in_band) begin
      map_o.tolerance = TolW'(DefaultVal);
      map_o.delay_ms  = DelayW'(DefaultVal);
    end else if (above_low) begin
      map_o.tolerance = TolW'(TolLow) + q_tol;
      map_o.delay_ms  = DelayW'(DelayHigh) - q_dly;
    end else begin
      map_o.tolerance = TolW'(TolLow) - q_tol;
      map_o.delay_ms  = DelayW'(DelayHigh) + q_dly;
    end
  end

endmodule

[rtl/lt_axis_step.sv]
// one axis: dead band check, one degree step and limit clamp
// depends on lt_pkg
module lt_axis_step import lt_pkg::*; (
  input  logic [AngleW-1:0]  pos_i,
  input  logic [SampleW-1:0] first_i,
  input  logic [SampleW-1:0] second_i,
  input  logic [TolW-1:0]    tol_i,
  input  lt_limit_t          limit_i,
  output logic [AngleW-1:0]  pos_o
);

  logic [SampleW-1:0] diff;
  logic               first_gt, first_lt, outside;
  logic [AngleW:0]    inc;
  logic [AngleW-1:0]  dec;

  always_comb begin
    first_gt = first_i > second_i;
    first_lt = first_i < second_i;
    diff     = first_gt ? (first_i - second_i) : (second_i - first_i);
    outside  = diff > SampleW'(tol_i);
    inc      = {1'b0, pos_i} + (AngleW+1)'(1);
    dec      = pos_i - AngleW'(1);
    pos_o    = pos_i;
    if (outside && first_gt) begin
      pos_o = (inc > {1'b0, limit_i.high}) ? limit_i.high : inc[AngleW-1:0];
    end else if (outside && first_lt) begin
      pos_o = ((pos_i == '0) || (dec < limit_i.low)) ? limit_i.low : dec;
    end
  end

endmodule

[rtl/four_sensor_light_tracker_step_core.sv]
// Four sensor light tracker step core. Takes one sample beat per clock while
// ready is high and returns one result beat per sample: one register holds
// the samples, the averaging, level mapping and both axis steps then run in
// a single combinational pass into the result register, which also updates
// the stored angles. Sustained rate is one beat per cycle; ready drops only
// while both the sample and result registers are full and the result is not
// taken. Limit registers should be written only while no beat is in flight.
// No clearing pass.
// depends on lt_pkg, lt_if, lt_level_map, lt_axis_step
module four_sensor_light_tracker_step_core import lt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  lt_in_if.sink               in_i,
  lt_out_if.source            out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [AngleW-1:0]   cfg_wdata_i
);

  logic [SampleW-1:0] tl_q, tr_q, bl_q, br_q;
  logic               s1_valid_q, s1_valid_d;
  logic               out_valid_q, out_valid_d;
  logic [AngleW-1:0]  horiz_q, horiz_d, vert_q, vert_d;
  logic [AngleW-1:0]  out_horiz_q, out_vert_q;
  logic [TolW-1:0]    out_tol_q;
  logic [DelayW-1:0]  out_dly_q;
  lt_limit_t          horiz_lim_q, vert_lim_q;
  lt_avg_t            avg;
  lt_map_t            map;
  logic               s2_ready, advance, in_take;
  lt_cfg_idx_e        cfg_idx;

  assign s2_ready   = !out_valid_q || out_o.ready;
  assign advance    = s1_valid_q && s2_ready;
  assign in_i.ready = !s1_valid_q || s2_ready;
  assign in_take    = in_i.valid && in_i.ready;
  assign cfg_idx    = lt_cfg_idx_e'(cfg_idx_i);

  assign s1_valid_d  = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
  assign out_valid_d = advance ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  lt_level_map u_level_map (
    .top_left_i     (tl_q),
    .top_right_i    (tr_q),
    .bottom_left_i  (bl_q),
    .bottom_right_i (br_q),
    .avg_o          (avg),
    .map_o          (map)
  );

  lt_axis_step u_vert_step (
    .pos_i    (vert_q),
    .first_i  (avg.top),
    .second_i (avg.bottom),
    .tol_i    (map.tolerance),
    .limit_i  (vert_lim_q),
    .pos_o    (vert_d)
  );

  lt_axis_step u_horiz_step (
    .pos_i    (horiz_q),
    .first_i  (avg.left),
    .second_i (avg.right),
    .tol_i    (map.tolerance),
    .limit_i  (horiz_lim_q),
    .pos_o    (horiz_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      horiz_q     <= HorizReset;
      vert_q      <= VertReset;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        horiz_q <= horiz_d;
        vert_q  <= vert_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      horiz_lim_q.low  <= LimitLowReset;
      horiz_lim_q.high <= LimitHighReset;
      vert_lim_q.low   <= LimitLowReset;
      vert_lim_q.high  <= LimitHighReset;
    end else if (cfg_we_i) begin
      case (cfg_idx)
        CfgHorizLow:  horiz_lim_q.low  <= cfg_wdata_i;
        CfgHorizHigh: horiz_lim_q.high <= cfg_wdata_i;
        CfgVertLow:   vert_lim_q.low   <= cfg_wdata_i;
        CfgVertHigh:  vert_lim_q.high  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      tl_q <= in_i.top_left;
      tr_q <= in_i.top_right;
      bl_q <= in_i.bottom_left;
      br_q <= in_i.bottom_right;
    end
    if (advance) begin
      out_horiz_q <= horiz_d;
      out_vert_q  <= vert_d;
      out_tol_q   <= map.tolerance;
      out_dly_q   <= map.delay_ms;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.horiz_angle = out_horiz_q;
  assign out_o.vert_angle  = out_vert_q;
  assign out_o.tolerance   = out_tol_q;
  assign out_o.delay_ms    = out_dly_q;

endmodule

[rtl/lt_checker.sv]
// port level checks for the tracker step core, bound to the top level
// depends on lt_pkg and four_sensor_light_tracker_step_core
module lt_checker import lt_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [AngleW-1:0] horiz_angle_i,
  input logic [TolW-1:0]   tolerance_i,
  input logic [DelayW-1:0] delay_ms_i
);

  // stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(horiz_angle_i)
      && $stable(tolerance_i) && $stable(delay_ms_i))
    else $error("stalled result beat changed");

  // mapping stays inside its output range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (tolerance_i <= TolW'(TolHigh)) && (delay_ms_i >= DelayW'(DelayLow))
      && (delay_ms_i <= DelayW'(DelayHigh + 1)))
    else $error("tolerance or delay out of range");

  // lowest delay only comes from the out of band default
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (delay_ms_i == DelayW'(DefaultVal)) |-> tolerance_i == TolW'(DefaultVal))
    else $error("delay default without tolerance default");

endmodule

bind four_sensor_light_tracker_step_core lt_checker u_lt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .horiz_angle_i (out_o.horiz_angle),
  .tolerance_i   (out_o.tolerance),
  .delay_ms_i    (out_o.delay_ms)
);

[sim/four_sensor_light_tracker_step_checker.sv]
`timescale 1ns / 100ps
// checker for the four sensor light tracker step core: watches the sample, result
// and limit write ports, predicts every result beat and compares it field by field
// depends on lt_pkg and lt_if
module four_sensor_light_tracker_step_checker import lt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  lt_in_if                   smp_i,
  lt_out_if                  res_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [AngleW-1:0]  cfg_wdata_i,
  output int                 fail_count_o,
  output int                 steps_due_o
);

  typedef struct packed {
    logic [AngleW-1:0] horiz_angle;
    logic [AngleW-1:0] vert_angle;
    logic [TolW-1:0]   tolerance;
    logic [DelayW-1:0] delay_ms;
  } track_step_t;

  track_step_t       step_q [$];
  lt_limit_t         horiz_lim;
  lt_limit_t         vert_lim;
  logic [AngleW-1:0] horiz_pos;
  logic [AngleW-1:0] vert_pos;

  function automatic logic [AngleW-1:0] step_axis(input logic [AngleW-1:0] pos,
                                                  input int first, input int second,
                                                  input int tol, input lt_limit_t lim);
    int p;
    int d;
    p = int'(pos);
    d = first - second;
    if (d > tol || d < -tol) begin
      if (first > second) begin
        p = p + 1;
        if (p > int'(lim.high)) p = int'(lim.high);
      end else if (first < second) begin
        p = p - 1;
        if (p < int'(lim.low)) p = int'(lim.low);
      end
    end
    return AngleW'(p);
  endfunction

  function automatic track_step_t predict_step(input logic [SampleW-1:0] tl, tr, bl, br,
                                               input logic [AngleW-1:0] h_pos, v_pos,
                                               input lt_limit_t h_lim, v_lim);
    int avg_t;
    int avg_b;
    int avg_l;
    int avg_r;
    int level;
    int tol;
    int dly;
    track_step_t res;
    avg_t = (int'(tl) + int'(tr)) / 2;
    avg_b = (int'(bl) + int'(br)) / 2;
    avg_l = (int'(tl) + int'(bl)) / 2;
    avg_r = (int'(tr) + int'(br)) / 2;
    level = (avg_t + avg_b + avg_l + avg_r) / 4;
    if (level > 0 && level < LevelMax) begin
      // signed division truncates toward zero, levels below 10 go past the ends
      tol = (level - MapInLow) * (TolHigh - TolLow) / MapSpan + TolLow;
      dly = (level - MapInLow) * (DelayLow - DelayHigh) / MapSpan + DelayHigh;
    end else begin
      tol = DefaultVal;
      dly = DefaultVal;
    end
    res.vert_angle  = step_axis(v_pos, avg_t, avg_b, tol, v_lim);
    res.horiz_angle = step_axis(h_pos, avg_l, avg_r, tol, h_lim);
    res.tolerance   = TolW'(tol);
    res.delay_ms    = DelayW'(dly);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count_o < 40) $display("%0t ns: %s", $realtime, msg);
    fail_count_o++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    track_step_t want;
    if (!rst_ni) begin
      horiz_lim    = '{low: LimitLowReset, high: LimitHighReset};
      vert_lim     = '{low: LimitLowReset, high: LimitHighReset};
      horiz_pos    = HorizReset;
      vert_pos     = VertReset;
      step_q.delete();
      steps_due_o  = 0;
    end else begin
      if (cfg_we_i) begin
        case (lt_cfg_idx_e'(cfg_idx_i))
          CfgHorizLow:  horiz_lim.low  = cfg_wdata_i;
          CfgHorizHigh: horiz_lim.high = cfg_wdata_i;
          CfgVertLow:   vert_lim.low   = cfg_wdata_i;
          CfgVertHigh:  vert_lim.high  = cfg_wdata_i;
          default: ;
        endcase
      end
      // result beats belong to older samples, so pop before pushing
      if (res_i.valid && res_i.ready) begin
        if (step_q.size() == 0) begin
          report_mismatch("result beat with no sample pending");
        end else begin
          want = step_q.pop_front();
          check_field("horiz_angle", int'(res_i.horiz_angle), int'(want.horiz_angle));
          check_field("vert_angle", int'(res_i.vert_angle), int'(want.vert_angle));
          check_field("tolerance", int'(res_i.tolerance), int'(want.tolerance));
          check_field("delay_ms", int'(res_i.delay_ms), int'(want.delay_ms));
        end
      end
      if (smp_i.valid && smp_i.ready) begin
        want = predict_step(smp_i.top_left, smp_i.top_right, smp_i.bottom_left,
                            smp_i.bottom_right, horiz_pos, vert_pos, horiz_lim, vert_lim);
        horiz_pos = want.horiz_angle;
        vert_pos  = want.vert_angle;
        step_q.push_back(want);
      end
      steps_due_o = step_q.size();
    end
  end

endmodule

[sim/four_sensor_light_tracker_step_core_tb.sv]
`timescale 1ns / 100ps
// testbench top for the four sensor light tracker step core: drives sample beats,
// limit writes and result back-pressure; the checker module predicts and compares
// depends on lt_pkg, lt_if, the core and four_sensor_light_tracker_step_checker
module four_sensor_light_tracker_step_core_tb;
  import lt_pkg::*;

  typedef enum {ZoneDark, ZoneMid, ZoneBright} light_zone_e;
  typedef enum {RdyOpen, RdyStall, RdyChoppy} ready_mode_e;

  localparam int NumLimitSets = 6;
  localparam int ItemsPerSet  = 85;

  // horiz low, horiz high, vert low, vert high
  localparam logic [AngleW-1:0] LimitSet [NumLimitSets][4] = '{
    '{9'd0,   9'd359, 9'd0,   9'd359},
    '{9'd100, 9'd102, 9'd90,  9'd93},
    '{9'd200, 9'd150, 9'd300, 9'd250},
    '{9'd0,   9'd511, 9'd511, 9'd0},
    '{9'd0,   9'd0,   9'd359, 9'd359},
    '{9'd0,   9'd270, 9'd0,   9'd270}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [AngleW-1:0]  cfg_wdata_i;
  int                 fail_count;
  int                 steps_due;

  int unsigned        burst_left;
  int unsigned        sweep_left;
  int                 vert_dir;
  int                 horiz_dir;
  light_zone_e        zone;
  ready_mode_e        rdy_mode;
  int unsigned        rdy_left;

  lt_in_if  smp_if ();
  lt_out_if res_if ();

  four_sensor_light_tracker_step_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (smp_if),
    .out_o       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  four_sensor_light_tracker_step_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .smp_i        (smp_if),
    .res_i        (res_if),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .steps_due_o  (steps_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // result side stalls on its own pattern of open, closed and choppy runs
  initial begin
    res_if.ready <= 1'b0;
    rdy_left = 0;
    forever begin
      @(posedge clk_i);
      if (rdy_left == 0) begin
        rdy_mode = ready_mode_e'($urandom_range(0, 2));
        rdy_left = $urandom_range(1, (rdy_mode == RdyOpen) ? 40 : 10);
      end
      rdy_left--;
      case (rdy_mode)
        RdyOpen:  res_if.ready <= 1'b1;
        RdyStall: res_if.ready <= 1'b0;
        default:  res_if.ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // one beat, then either stay in the burst or drop valid for a random gap
  task automatic send_sample(input logic [SampleW-1:0] tl, tr, bl, br);
    smp_if.valid        <= 1'b1;
    smp_if.top_left     <= tl;
    smp_if.top_right    <= tr;
    smp_if.bottom_left  <= bl;
    smp_if.bottom_right <= br;
    @(posedge clk_i);
    while (!smp_if.ready) @(posedge clk_i);
    if (burst_left == 0) begin
      smp_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_drained();
    smp_if.valid <= 1'b0;
    @(posedge clk_i);
    while (steps_due != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_limits(input int sel);
    lt_cfg_idx_e idx;
    idx = CfgHorizLow;
    repeat (4) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx;
      cfg_wdata_i <= LimitSet[sel][int'(idx)];
      @(posedge clk_i);
      idx = idx.next();
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [SampleW-1:0] clamp_sample(input int v);
    if (v < 0) return '0;
    if (v > 1023) return '1;
    return SampleW'(v);
  endfunction

  // mostly sweeps that push one way for a while, so the angles reach their limits
  task automatic send_random_sample();
    int base;
    int mag;
    int dv;
    int dh;
    if (sweep_left == 0) begin
      sweep_left = $urandom_range(5, 80);
      vert_dir   = int'($urandom_range(0, 2)) - 1;
      horiz_dir  = int'($urandom_range(0, 2)) - 1;
      zone       = light_zone_e'($urandom_range(0, 2));
    end
    sweep_left--;
    if ($urandom_range(0, 4) == 0) begin
      send_sample(SampleW'($urandom), SampleW'($urandom), SampleW'($urandom),
                  SampleW'($urandom));
    end else begin
      case (zone)
        ZoneDark: base = $urandom_range(0, 40);
        ZoneMid:  base = $urandom_range(10, 310);
        default:  base = $urandom_range(280, 1023);
      endcase
      mag = $urandom_range(0, 150);
      dv  = vert_dir * mag;
      dh  = horiz_dir * mag;
      send_sample(clamp_sample(base + dv + dh), clamp_sample(base + dv - dh),
                  clamp_sample(base - dv + dh), clamp_sample(base - dv - dh));
    end
  endtask

  initial begin
    rst_ni              <= 1'b0;
    smp_if.valid        <= 1'b0;
    smp_if.top_left     <= '0;
    smp_if.top_right    <= '0;
    smp_if.bottom_left  <= '0;
    smp_if.bottom_right <= '0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= CfgHorizLow;
    cfg_wdata_i         <= '0;
    burst_left = 0;
    sweep_left = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part under the reset limits
    send_sample(10'd0, 10'd0, 10'd0, 10'd0);
    send_sample(10'd1023, 10'd1023, 10'd1023, 10'd1023);
    send_sample(10'd1, 10'd1, 10'd1, 10'd1);
    send_sample(10'd9, 10'd9, 10'd9, 10'd9);
    send_sample(10'd10, 10'd10, 10'd10, 10'd10);
    send_sample(10'd299, 10'd299, 10'd299, 10'd299);
    send_sample(10'd300, 10'd300, 10'd300, 10'd300);
    // difference equal to the dead band, then just past it
    send_sample(10'd117, 10'd117, 10'd83, 10'd83);
    send_sample(10'd118, 10'd118, 10'd82, 10'd82);
    send_sample(10'd82, 10'd82, 10'd118, 10'd118);
    send_sample(10'd117, 10'd83, 10'd117, 10'd83);
    send_sample(10'd118, 10'd82, 10'd118, 10'd82);
    send_sample(10'd82, 10'd118, 10'd82, 10'd118);
    send_sample(10'd1023, 10'd0, 10'd0, 10'd0);
    send_sample(10'd0, 10'd1023, 10'd0, 10'd0);
    send_sample(10'd0, 10'd0, 10'd1023, 10'd0);
    send_sample(10'd0, 10'd0, 10'd0, 10'd1023);
    send_sample(10'd1023, 10'd1023, 10'd0, 10'd0);
    send_sample(10'd682, 10'd341, 10'd341, 10'd682);
    wait_drained();

    for (int sel = 0; sel < NumLimitSets; sel++) begin
      write_limits(sel);
      repeat (ItemsPerSet) begin
        send_random_sample();
        if ($urandom_range(0, 39) == 0) wait_drained();
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
